### rtl/dpq_pkg.sv
// Shared types and constants for the descriptor pool with two queues.
package dpq_pkg;

    localparam int ENTRY_W = 6;
    localparam int COUNT_W = 7;
    localparam int DEFAULT_MAX_ENTRIES = 64;
    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 7'd64;

    // link word: {end of freed stack, next entry}
    localparam int LINK_W = ENTRY_W + 1;

    localparam logic [2:0] CMD_INIT  = 3'd0;
    localparam logic [2:0] CMD_ALLOC = 3'd1;
    localparam logic [2:0] CMD_ENQ   = 3'd2;
    localparam logic [2:0] CMD_DEQ   = 3'd3;
    localparam logic [2:0] CMD_REL   = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic               queue_select;
        logic [ENTRY_W-1:0] entry;
    } cmd_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] result_entry;
        logic [1:0]         status;
    } rsp_t;

endpackage

### rtl/dpq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/dpq_ctrl.sv
// Command sequencer: free list, two queues, link memory read-modify-write.
module dpq_ctrl import dpq_pkg::*; #(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES,
    localparam int LINK_DEPTH = (MAX_ENTRIES < (1 << ENTRY_W)) ? MAX_ENTRIES : (1 << ENTRY_W),
    localparam int AW = $clog2(LINK_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] entry_count,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    output logic               link_we,
    output logic [AW-1:0]      link_waddr,
    output logic [LINK_W-1:0]  link_wdata,
    output logic               link_re,
    output logic [AW-1:0]      link_raddr,
    input  logic [LINK_W-1:0]  link_rdata
);

    localparam int CLAMP_I = (MAX_ENTRIES > (1 << COUNT_W) - 1) ? (1 << COUNT_W) - 1 : MAX_ENTRIES;
    localparam logic [COUNT_W-1:0] CLAMP = COUNT_W'(CLAMP_I);
    localparam logic [COUNT_W-1:0] ACTIVE_RESET =
        (ENTRY_COUNT_RESET > CLAMP) ? CLAMP : ENTRY_COUNT_RESET;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t             state_reg;
    logic [COUNT_W-1:0] active_reg;
    logic [COUNT_W-1:0] fresh_reg;
    logic [ENTRY_W-1:0] freed_top_reg;
    logic               freed_ne_reg;
    logic [ENTRY_W-1:0] head_reg [2];
    logic [ENTRY_W-1:0] tail_reg [2];
    logic [1:0]         qne_reg;
    logic               pend_alloc_reg;
    logic               pend_q_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic accept;
    logic in_range;
    logic q;

    assign cmd_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = cmd_valid && cmd_ready;
    assign q         = cmd.queue_select;
    assign in_range  = {1'b0, cmd.entry} < active_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = cmd.entry[AW-1:0];
        link_wdata = {1'b0, cmd.entry};
        link_re    = 1'b0;
        link_raddr = freed_top_reg[AW-1:0];
        if (accept)
        begin
            unique case (cmd.command)
                CMD_ALLOC:
                begin
                    link_re = freed_ne_reg;
                end
                CMD_ENQ:
                begin
                    link_we    = in_range && qne_reg[q];
                    link_waddr = tail_reg[q][AW-1:0];
                end
                CMD_DEQ:
                begin
                    link_re    = qne_reg[q] && (head_reg[q] != tail_reg[q]);
                    link_raddr = head_reg[q][AW-1:0];
                end
                CMD_REL:
                begin
                    link_we    = in_range;
                    link_wdata = {~freed_ne_reg, freed_top_reg};
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= ACTIVE_RESET;
            fresh_reg      <= '0;
            freed_top_reg  <= '0;
            freed_ne_reg   <= 1'b0;
            head_reg[0]    <= '0;
            head_reg[1]    <= '0;
            tail_reg[0]    <= '0;
            tail_reg[1]    <= '0;
            qne_reg        <= '0;
            pend_alloc_reg <= 1'b0;
            pend_q_reg     <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        // requests that read the link memory answer from S_READ
                        rsp_valid_reg <= !link_re;
                        unique case (cmd.command)
                            CMD_INIT:
                            begin
                                rsp_reg       <= '{result_entry: '0, status: STATUS_OK};
                                active_reg    <= (entry_count > CLAMP) ? CLAMP : entry_count;
                                fresh_reg     <= '0;
                                freed_top_reg <= '0;
                                freed_ne_reg  <= 1'b0;
                                head_reg[0]   <= '0;
                                head_reg[1]   <= '0;
                                tail_reg[0]   <= '0;
                                tail_reg[1]   <= '0;
                                qne_reg       <= '0;
                            end
                            CMD_ALLOC:
                            begin
                                if (freed_ne_reg)
                                begin
                                    // new stack top comes back from the link memory
                                    pend_alloc_reg <= 1'b1;
                                    state_reg      <= S_READ;
                                end
                                else if (fresh_reg < active_reg)
                                begin
                                    rsp_reg   <= '{result_entry: fresh_reg[ENTRY_W-1:0],
                                                   status: STATUS_OK};
                                    fresh_reg <= fresh_reg + 1'b1;
                                end
                                else
                                begin
                                    rsp_reg <= '{result_entry: '0, status: STATUS_EMPTY};
                                end
                            end
                            CMD_ENQ:
                            begin
                                if (!in_range)
                                begin
                                    rsp_reg <= '{result_entry: '0, status: STATUS_RANGE};
                                end
                                else
                                begin
                                    rsp_reg <= '{result_entry: '0, status: STATUS_OK};
                                    if (!qne_reg[q])
                                    begin
                                        head_reg[q] <= cmd.entry;
                                    end
                                    tail_reg[q] <= cmd.entry;
                                    qne_reg[q]  <= 1'b1;
                                end
                            end
                            CMD_DEQ:
                            begin
                                if (!qne_reg[q])
                                begin
                                    rsp_reg <= '{result_entry: '0, status: STATUS_EMPTY};
                                end
                                else if (head_reg[q] == tail_reg[q])
                                begin
                                    rsp_reg    <= '{result_entry: head_reg[q], status: STATUS_OK};
                                    qne_reg[q] <= 1'b0;
                                end
                                else
                                begin
                                    pend_alloc_reg <= 1'b0;
                                    pend_q_reg     <= q;
                                    state_reg      <= S_READ;
                                end
                            end
                            CMD_REL:
                            begin
                                if (!in_range)
                                begin
                                    rsp_reg <= '{result_entry: '0, status: STATUS_RANGE};
                                end
                                else
                                begin
                                    rsp_reg       <= '{result_entry: '0, status: STATUS_OK};
                                    freed_top_reg <= cmd.entry;
                                    freed_ne_reg  <= 1'b1;
                                end
                            end
                            default:
                            begin
                                rsp_reg <= '{result_entry: '0, status: STATUS_OK};
                            end
                        endcase
                    end
                    else if (rsp_valid_reg && rsp_ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                    end
                end
                S_READ:
                begin
                    rsp_valid_reg <= 1'b1;
                    if (pend_alloc_reg)
                    begin
                        rsp_reg       <= '{result_entry: freed_top_reg, status: STATUS_OK};
                        freed_top_reg <= link_rdata[ENTRY_W-1:0];
                        freed_ne_reg  <= ~link_rdata[ENTRY_W];
                    end
                    else
                    begin
                        rsp_reg <= '{result_entry: head_reg[pend_q_reg], status: STATUS_OK};
                        head_reg[pend_q_reg] <= link_rdata[ENTRY_W-1:0];
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/descriptor_pool_with_two_queues_unit.sv
// Top level of the descriptor pool: count register, sequencer and link memory.
//
// Requests arrive on cmd (cmd_valid/cmd_ready) and each one yields exactly one
// response on rsp (rsp_valid/rsp_ready), in request order. Commands are init,
// allocate, enqueue, dequeue and release; the free stack and both queues are
// chained through one shared link memory of MAX_ENTRIES (at most 64) words.
// The entry_count register is written through cfg_valid/cfg_ready/cfg_data,
// always ready, and takes effect at the next init request.
// Most commands answer from the response register in the cycle after the request is
// taken. An allocate from the freed stack or a dequeue that leaves entries behind
// reads the link memory and answers from the S_READ state. One request is in work
// at a time, so no new request is taken while the link memory read is pending.
// A new request is taken in the cycle the pending response is taken.
// While a response is pending and rsp_ready is low, the response register holds and cmd_ready is low.
// After reset the queues and freed stack are empty, all entries are fresh and
// the count is 64 clamped to MAX_ENTRIES, so no init is needed. No clearing
// pass runs: link words are always written before they are read.
module descriptor_pool_with_two_queues_unit import dpq_pkg::*; #(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp
);

    localparam int LINK_DEPTH = (MAX_ENTRIES < (1 << ENTRY_W)) ? MAX_ENTRIES : (1 << ENTRY_W);
    localparam int AW = $clog2(LINK_DEPTH);

    logic [COUNT_W-1:0] entry_count_reg;
    logic               link_we;
    logic [AW-1:0]      link_waddr;
    logic [LINK_W-1:0]  link_wdata;
    logic               link_re;
    logic [AW-1:0]      link_raddr;
    logic [LINK_W-1:0]  link_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    dpq_ctrl #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .entry_count(entry_count_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_re    (link_re),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata)
    );

    dpq_ram #(
        .WIDTH(LINK_W),
        .DEPTH(LINK_DEPTH)
    ) u_link_ram (
        .clk  (clk),
        .we   (link_we),
        .waddr(link_waddr),
        .wdata(link_wdata),
        .re   (link_re),
        .raddr(link_raddr),
        .rdata(link_rdata)
    );

endmodule
